@@ sv/stp_pkg.sv @@
// Shared types and constants for the software timer pool.
package stp_pkg;

   localparam int NUM_TIMERS  = 32;
   localparam int STORE_DEPTH = 32;
   localparam int SLOT_COUNT  = (NUM_TIMERS < STORE_DEPTH) ? NUM_TIMERS : STORE_DEPTH;
   localparam int HANDLE_W    = 5;
   localparam int TICK_W      = 32;
   localparam int MODE_W      = 3;

   localparam logic [TICK_W-1:0] TICK_STEP = TICK_W'(1);

   localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CHECK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RESTART = 3'd4;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_ALLOC,
      OP_RELEASE,
      OP_CHECK,
      OP_RESTART,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [HANDLE_W-1:0] handle;
      logic [TICK_W-1:0]   duration;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] result_handle;
      logic                accepted;
      logic                expired;
   } rsp_type;

   typedef struct packed {
      op_type              op;
      logic [HANDLE_W-1:0] handle;
      logic                in_range;
      logic [TICK_W-1:0]   duration;
   } cmd_type;

endpackage

@@ sv/stp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module stp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/stp_front.sv @@
// Request decoder: turns a mode and handle into a command for the queue.
module stp_front import stp_pkg::*; (
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    cmd_valid,
   input  logic    cmd_stall,
   output cmd_type cmd
);

   op_type op;

   always_comb begin
      unique case (req_payload.mode)
         MODE_TICK:    op = OP_TICK;
         MODE_ALLOC:   op = OP_ALLOC;
         MODE_RELEASE: op = OP_RELEASE;
         MODE_CHECK:   op = OP_CHECK;
         MODE_RESTART: op = OP_RESTART;
         default:      op = OP_NONE;
      endcase
   end

   always_comb begin
      cmd.op       = op;
      cmd.handle   = req_payload.handle;
      cmd.in_range = (req_payload.handle != '0) && (int'(req_payload.handle) < SLOT_COUNT);
      cmd.duration = req_payload.duration;
   end

   assign cmd_valid = req_valid;
   assign req_stall = cmd_stall;

endmodule

@@ sv/stp_queue.sv @@
// Two-entry command queue between the decoder and the execution unit.
module stp_queue import stp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_pop,
   output cmd_type out_cmd
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;
   logic       pop;

   assign in_stall  = (count_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign out_valid = (count_ff != 2'd0);
   assign pop       = out_pop && out_valid;
   assign out_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

@@ sv/stp_back.sv @@
// Execution unit: tick counter, slot flags, deadline store and result register.
module stp_back import stp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   typedef enum logic {
      ST_IDLE,
      ST_COMPARE
   } state_type;

   state_type              state_ff;
   state_type              state_in;
   logic [TICK_W-1:0]      tick_ff;
   logic [TICK_W-1:0]      tick_in;
   logic [STORE_DEPTH-1:0] in_use_ff;
   logic [STORE_DEPTH-1:0] in_use_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic                   free_found;
   logic [HANDLE_W-1:0]    free_idx;
   logic                   hit;
   logic [TICK_W-1:0]      deadline_new;
   logic                   ram_wr_en;
   logic [HANDLE_W-1:0]    ram_wr_addr;
   logic                   ram_rd_en;
   logic [TICK_W-1:0]      ram_rd_data;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 1; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = HANDLE_W'(i);
         end
      end
   end

   assign hit          = cmd.in_range && in_use_ff[cmd.handle];
   assign deadline_new = cmd.duration + tick_ff;
   assign cmd_pop      = (state_ff == ST_IDLE) && cmd_valid && (!rsp_valid_ff || !rsp_stall);
   assign ram_wr_en    = cmd_pop && (((cmd.op == OP_ALLOC) && free_found) ||
                                     ((cmd.op == OP_RESTART) && hit));
   assign ram_wr_addr  = (cmd.op == OP_ALLOC) ? free_idx : cmd.handle;
   assign ram_rd_en    = cmd_pop && (cmd.op == OP_CHECK) && hit;

   stp_ram #(
      .WIDTH (TICK_W),
      .DEPTH (STORE_DEPTH)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (deadline_new),
      .rd_en   (ram_rd_en),
      .rd_addr (cmd.handle),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      in_use_in    = in_use_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               case (cmd.op)
                  OP_TICK: begin
                     tick_in = tick_ff + TICK_STEP;
                  end
                  OP_ALLOC: begin
                     if (free_found) begin
                        in_use_in[free_idx]  = 1'b1;
                        rsp_in.result_handle = free_idx;
                        rsp_in.accepted      = 1'b1;
                     end
                  end
                  OP_RELEASE: begin
                     if (hit) begin
                        in_use_in[cmd.handle] = 1'b0;
                        rsp_in.accepted       = 1'b1;
                     end else begin
                        rsp_in.result_handle = cmd.handle;
                     end
                  end
                  OP_CHECK: begin
                     if (hit) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_COMPARE;
                     end
                  end
                  OP_RESTART: begin
                     rsp_in.accepted = hit;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COMPARE: begin
            rsp_valid_in         = 1'b1;
            rsp_in.result_handle = '0;
            rsp_in.accepted      = 1'b1;
            rsp_in.expired       = (ram_rd_data < tick_ff);
            state_in             = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         in_use_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         in_use_ff    <= in_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ sv/software_timer_pool.sv @@
// Top level of the software timer pool: decoder, command queue and execution unit.
// A request accepted into the queue is held in a queue entry and, once popped, in the
// response register; a check of a valid handle also passes the registered deadline read and
// the compare state. Throughput: one request per cycle while responses are not stalled; the
// single execution unit takes no new command in the compare state after a valid check.
// Reset clears the tick counter, all slot flags, the queue and the response valid flag.
module software_timer_pool import stp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    fe_valid;
   logic    fe_stall;
   cmd_type fe_cmd;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   stp_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (fe_valid),
      .cmd_stall   (fe_stall),
      .cmd         (fe_cmd)
   );

   stp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_stall  (fe_stall),
      .in_cmd    (fe_cmd),
      .out_valid (q_valid),
      .out_pop   (q_pop),
      .out_cmd   (q_cmd)
   );

   stp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (q_valid),
      .cmd         (q_cmd),
      .cmd_pop     (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command popped from empty queue");

   a_pop_not_blocked: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && rsp_valid && rsp_stall))
      else $error("command popped while response register is blocked");

   a_expired_accepted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.expired) |-> (rsp_payload.accepted &&
                                              rsp_payload.result_handle == '0))
      else $error("expiry reported without an accepted check");

   a_handle_in_pool: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.accepted) |-> (int'(rsp_payload.result_handle) < SLOT_COUNT))
      else $error("accepted response carries a handle outside the pool");
`endif

endmodule
